[rtl/bsfx_pkg.sv]
// bsfx_pkg: shared types and constants of the byte stuffing framer
// holds the register map, reset values, queue entry and sequencer phases
// no dependencies
package bsfx_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SUB  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_SUB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SEQ0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SEQ1 = 3'd6;

  localparam logic [BYTE_W-1:0] RST_FLAG      = 8'h7E;
  localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'h7D;
  localparam logic [BYTE_W-1:0] RST_FLAG_SUB  = 8'h5E;
  localparam logic [BYTE_W-1:0] RST_ESC_SUB   = 8'h5D;
  localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'h03;
  localparam logic [BYTE_W-1:0] RST_CTRL_SEQ0 = 8'h00;
  localparam logic [BYTE_W-1:0] RST_CTRL_SEQ1 = 8'h40;

  localparam logic [BYTE_W-1:0] CHECK_INIT = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] escape_value;
    logic [BYTE_W-1:0] flag_substitute;
    logic [BYTE_W-1:0] escape_substitute;
    logic [BYTE_W-1:0] address_value;
    logic [BYTE_W-1:0] control_seq_zero;
    logic [BYTE_W-1:0] control_seq_one;
  } bsfx_cfg_t;

  // one classified input word, as handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] payload;
    logic [BYTE_W-1:0] check;
    logic              first;
    logic              last;
    logic              seq;
  } bsfx_job_t;

  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_HCS,
    PH_DATA,
    PH_DATA_SUB,
    PH_CHK,
    PH_CHK_SUB,
    PH_CLOSE
  } bsfx_phase_t;

endpackage

[rtl/bsfx_if.sv]
// bsfx_if: valid/ready channel interfaces of the byte stuffing framer
// input channel carries payload words, output channel carries line bytes
// no dependencies
interface bsfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;
  logic       sequence_bit;

  modport source (output valid, output payload_byte, output first_byte,
                  output last_byte, output sequence_bit, input ready);
  modport sink   (input valid, input payload_byte, input first_byte,
                  input last_byte, input sequence_bit, output ready);
endinterface

interface bsfx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_end;
  logic       frame_end;

  modport source (output valid, output line_byte, output run_end,
                  output frame_end, input ready);
  modport sink   (input valid, input line_byte, input run_end,
                  input frame_end, output ready);
endinterface

[rtl/bsfx_front.sv]
// bsfx_front: accepts payload words and keeps the running payload check
// depends on bsfx_pkg and bsfx_in_if
module bsfx_front (
  input  logic              clk,
  input  logic              rst_n,
  bsfx_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              q_push,
  output bsfx_pkg::bsfx_job_t q_job
);
  import bsfx_pkg::*;

  logic [BYTE_W-1:0] xor_r;
  logic [BYTE_W-1:0] xor_nxt;
  logic [BYTE_W-1:0] check;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // a first mark restarts the check, a last mark hands it over and rearms
  assign check   = (in_ch.first_byte ? CHECK_INIT : xor_r) ^ in_ch.payload_byte;
  assign xor_nxt = q_push ? (in_ch.last_byte ? CHECK_INIT : check) : xor_r;

  always_comb begin
    q_job.payload = in_ch.payload_byte;
    q_job.check   = check;
    q_job.first   = in_ch.first_byte;
    q_job.last    = in_ch.last_byte;
    q_job.seq     = in_ch.sequence_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r <= CHECK_INIT;
    end else begin
      xor_r <= xor_nxt;
    end
  end

endmodule

[rtl/bsfx_queue.sv]
// bsfx_queue: small first-in first-out queue of classified words
// depends on bsfx_pkg
module bsfx_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bsfx_pkg::bsfx_job_t push_job,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output bsfx_pkg::bsfx_job_t head_job
);
  import bsfx_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bsfx_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/bsfx_back.sv]
// bsfx_back: sequencer that expands one queued word into line bytes
// depends on bsfx_pkg and bsfx_out_if
module bsfx_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bsfx_pkg::bsfx_cfg_t cfg,
  input  logic                q_not_empty,
  input  bsfx_pkg::bsfx_job_t q_head,
  output logic                q_pop,
  bsfx_out_if.source          out_ch
);
  import bsfx_pkg::*;

  bsfx_job_t         job_r, job_nxt;
  logic              job_valid_r, job_valid_nxt;
  bsfx_phase_t       phase_r, phase_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_run_end_r;
  logic              out_frame_end_r;

  logic              out_free;
  logic              emit;
  logic [BYTE_W-1:0] ctrl;
  logic              data_hit, chk_hit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_done;
  logic              emit_frame_end;
  bsfx_phase_t       step_phase;

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = job_valid_r && out_free;
  assign ctrl     = job_r.seq ? cfg.control_seq_one : cfg.control_seq_zero;
  assign data_hit = (job_r.payload == cfg.escape_value) ||
                    (job_r.payload == cfg.flag_value);
  assign chk_hit  = (job_r.check == cfg.escape_value) ||
                    (job_r.check == cfg.flag_value);

  // outputs of the current phase
  always_comb begin
    emit_byte      = cfg.flag_value;
    emit_done      = 1'b0;
    emit_frame_end = 1'b0;
    case (phase_r)
      PH_FLAG:     emit_byte = cfg.flag_value;
      PH_ADDR:     emit_byte = cfg.address_value;
      PH_CTRL:     emit_byte = ctrl;
      PH_HCS:      emit_byte = cfg.address_value ^ ctrl;
      PH_DATA: begin
        emit_byte = data_hit ? cfg.escape_value : job_r.payload;
        emit_done = !data_hit && !job_r.last;
      end
      PH_DATA_SUB: begin
        // escape match wins over flag match
        emit_byte = (job_r.payload == cfg.escape_value) ?
                    cfg.escape_substitute : cfg.flag_substitute;
        emit_done = !job_r.last;
      end
      PH_CHK:      emit_byte = chk_hit ? cfg.escape_value : job_r.check;
      PH_CHK_SUB: begin
        emit_byte = (job_r.check == cfg.escape_value) ?
                    cfg.escape_substitute : cfg.flag_substitute;
      end
      PH_CLOSE: begin
        emit_byte      = cfg.flag_value;
        emit_done      = 1'b1;
        emit_frame_end = 1'b1;
      end
      default: begin
        emit_byte = cfg.flag_value;
      end
    endcase
  end

  // next state of the sequencer
  always_comb begin
    case (phase_r)
      PH_FLAG:     step_phase = PH_ADDR;
      PH_ADDR:     step_phase = PH_CTRL;
      PH_CTRL:     step_phase = PH_HCS;
      PH_HCS:      step_phase = PH_DATA;
      PH_DATA:     step_phase = data_hit ? PH_DATA_SUB : PH_CHK;
      PH_DATA_SUB: step_phase = PH_CHK;
      PH_CHK:      step_phase = chk_hit ? PH_CHK_SUB : PH_CLOSE;
      PH_CHK_SUB:  step_phase = PH_CLOSE;
      default:     step_phase = PH_CLOSE;
    endcase

    q_pop         = q_not_empty && (!job_valid_r || (emit && emit_done));
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    phase_nxt     = phase_r;
    if (q_pop) begin
      job_nxt       = q_head;
      job_valid_nxt = 1'b1;
      phase_nxt     = q_head.first ? PH_FLAG : PH_DATA;
    end else if (emit) begin
      job_valid_nxt = !emit_done;
      phase_nxt     = step_phase;
    end

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.line_byte = out_byte_r;
  assign out_ch.run_end   = out_run_end_r;
  assign out_ch.frame_end = out_frame_end_r;

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      out_byte_r      <= emit_byte;
      out_run_end_r   <= emit_done;
      out_frame_end_r <= emit_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      phase_r     <= PH_DATA;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/byte_stuffing_framer_xor_check_unit.sv]
// byte_stuffing_framer_xor_check_unit: framing transmitter top level
// depends on bsfx_pkg, bsfx_if, bsfx_front, bsfx_queue and bsfx_back
//
// Takes one payload word per handshake and emits the framed, byte-stuffed
// line stream one byte per cycle while out_ch is ready. A word costs 1 line
// byte, plus 4 header bytes with the first mark, plus 2 trailer bytes (check
// and closing flag) with the last mark, plus one byte for each stuffed
// payload or check byte; the back sequencer emits exactly one of these per
// cycle (one word a cycle for plain mid-frame bytes; stuffing lowers the
// rate). The front accepts a word every cycle while the QUEUE_DEPTH-entry
// queue has room; with the back idle, a word passes the queue and the job
// and output registers before its first line byte. The user must write the
// registers via cfg_we/cfg_index/cfg_wdata only while the block is idle,
// which it does not enforce; indexes past the register map are ignored.
module byte_stuffing_framer_xor_check_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bsfx_in_if.sink                            in_ch,
  bsfx_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [bsfx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsfx_pkg::BYTE_W-1:0]        cfg_wdata
);
  import bsfx_pkg::*;

  bsfx_cfg_t cfg_r, cfg_nxt;
  bsfx_job_t push_job, head_job;
  logic      q_push, q_pop, q_full, q_not_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FLAG:      cfg_nxt.flag_value        = cfg_wdata;
        CFG_ESCAPE:    cfg_nxt.escape_value      = cfg_wdata;
        CFG_FLAG_SUB:  cfg_nxt.flag_substitute   = cfg_wdata;
        CFG_ESC_SUB:   cfg_nxt.escape_substitute = cfg_wdata;
        CFG_ADDRESS:   cfg_nxt.address_value     = cfg_wdata;
        CFG_CTRL_SEQ0: cfg_nxt.control_seq_zero  = cfg_wdata;
        CFG_CTRL_SEQ1: cfg_nxt.control_seq_one   = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value        <= RST_FLAG;
      cfg_r.escape_value      <= RST_ESCAPE;
      cfg_r.flag_substitute   <= RST_FLAG_SUB;
      cfg_r.escape_substitute <= RST_ESC_SUB;
      cfg_r.address_value     <= RST_ADDRESS;
      cfg_r.control_seq_zero  <= RST_CTRL_SEQ0;
      cfg_r.control_seq_one   <= RST_CTRL_SEQ1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsfx_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  bsfx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  bsfx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

[rtl/bsfx_check.sv]
// bsfx_check: port-level assertions for the framer top level
// bound to byte_stuffing_framer_xor_check_unit; no other dependencies
module bsfx_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_line_byte,
  input logic       out_run_end,
  input logic       out_frame_end
);

  logic [7:0] pending_r;
  logic       in_acc, out_last_acc;

  assign in_acc       = in_valid && in_ready;
  assign out_last_acc = out_valid && out_ready && out_run_end;

  // words accepted whose last line byte has not gone out yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {7'd0, in_acc} - {7'd0, out_last_acc};
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_byte) &&
    $stable(out_run_end) && $stable(out_frame_end))
    else $error("stalled output changed");

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_end)
    else $error("closing flag not last byte of its word");

  a_no_invented_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_acc |-> pending_r != 8'd0)
    else $error("run end with no word outstanding");

endmodule

bind byte_stuffing_framer_xor_check_unit bsfx_check u_bsfx_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_line_byte (out_ch.line_byte),
  .out_run_end   (out_ch.run_end),
  .out_frame_end (out_ch.frame_end)
);
